/* rtl/assert_macros.svh */
// Assertion macros shared by the TIM element builder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

/* rtl/dtimtim_pkg.sv */
// Types and constants for the DTIM count and TIM element builder
`timescale 1ns / 1ps
package dtimtim_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_BUILD   = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_RELOAD  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_CTRL,
        ST_CALC,
        ST_BYTES
    } ctl_state_t;

    localparam logic CFG_DTIM_PERIOD  = 1'b0;
    localparam logic CFG_BITMAP_LIMIT = 1'b1;

    localparam logic [7:0] TIM_EID        = 8'd5;
    localparam logic [7:0] TIM_FIXED_BODY = 8'd3;
    localparam logic [8:0] TIM_HEADER     = 9'd5;
    localparam logic [7:0] LEN_ADDR       = 8'd0;
    localparam logic [7:0] CTRL_ADDR      = 8'd1;
    localparam logic [7:0] BITMAP_BASE    = 8'd2;

    typedef struct packed {
        logic wr_store;
        logic rd_len;
        logic rd_ctrl;
        logic load_setup;
        logic step;
        logic dtim_adv;
        logic dtim_reload;
    } ctl_cmd_t;

    typedef struct packed {
        logic word_done;
        logic last_byte;
        logic out_free;
    } dp_sts_t;

endpackage

/* rtl/dtimtim_ram.sv */
// Single-port RAM with registered read
`timescale 1ns / 1ps
module dtimtim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

/* rtl/dtimtim_ctrl.sv */
// Controller state machine for the TIM element builder
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtimtim_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  dtimtim_pkg::req_type_t s_req,
    output logic                   s_ready,
    output dtimtim_pkg::ctl_cmd_t  cmd,
    input  dtimtim_pkg::dp_sts_t   sts
);
    import dtimtim_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_req)
                        REQ_WRITE:   cmd.wr_store = 1'b1;
                        REQ_BUILD: begin
                            cmd.rd_len = 1'b1;
                            state_next = ST_RD_CTRL;
                        end
                        REQ_ADVANCE: cmd.dtim_adv = 1'b1;
                        REQ_RELOAD:  cmd.dtim_reload = 1'b1;
                        default:     cmd = '0;
                    endcase
                end
            end
            ST_RD_CTRL: begin
                cmd.rd_ctrl = 1'b1;
                state_next  = ST_CALC;
            end
            ST_CALC: begin
                cmd.load_setup = 1'b1;
                state_next     = ST_BYTES;
            end
            ST_BYTES: begin
                cmd.step = !sts.word_done || sts.out_free;
                if (cmd.step && sts.last_byte) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_step_needs_room, cmd.step && sts.word_done |-> sts.out_free, "output full")
    `ASSERT_NEVER(a_accept_only_idle, s_ready && (state_reg != ST_IDLE), "taken in build")
endmodule

/* rtl/dtimtim_dp.sv */
// Datapath: bitmap store, DTIM counter, element byte sequencing and packing
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtimtim_dp #(
    parameter int STORE_DEPTH    = 256,
    parameter int BYTES_PER_WORD = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dtimtim_pkg::ctl_cmd_t cmd,
    output dtimtim_pkg::dp_sts_t  sts,
    input  logic [7:0]            store_address,
    input  logic [7:0]            store_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [63:0]           m_element_word,
    output logic [3:0]            m_byte_count,
    output logic                  m_last_word,
    output logic [7:0]            m_element_length,
    output logic                  m_mcast_buffered
);
    import dtimtim_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [3:0] BPW_CNT = 4'(BYTES_PER_WORD);
    localparam logic [3:0] BPW_M1  = 4'(BYTES_PER_WORD - 1);

    typedef logic [IDX_W-1:0] wrap_lut_t [256];

    function automatic wrap_lut_t build_wrap_lut();
        wrap_lut_t lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = IDX_W'(i % STORE_DEPTH);
        end
        return lut;
    endfunction

    localparam wrap_lut_t WRAP_LUT = build_wrap_lut();

    logic [7:0]  period_reg;
    logic [7:0]  limit_reg;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  len_raw_reg;
    logic [7:0]  len_reg;
    logic [7:0]  ctrl_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [8:0]  total_reg;
    logic [8:0]  pos_reg;
    logic [63:0] asm_word_reg;
    logic [3:0]  asm_cnt_reg;
    logic        out_valid_reg;
    logic [63:0] out_word_reg;
    logic [3:0]  out_cnt_reg;
    logic        out_last_reg;
    logic [7:0]  out_len_reg;
    logic        out_mcast_reg;

    logic             ram_en;
    logic [IDX_W-1:0] ram_addr;
    logic [IDX_W-1:0] rd_ptr_inc;
    logic [7:0]       ram_rdata;
    logic [8:0]       pos_next;
    logic [7:0]       offset_calc;
    logic [8:0]       reach;
    logic [7:0]       len_calc;
    logic [7:0]       cur_byte;
    logic [63:0]      new_word;

    assign pos_next   = pos_reg + 9'd1;
    assign rd_ptr_inc = (rd_ptr_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        if (cmd.wr_store) begin
            ram_addr = WRAP_LUT[store_address];
        end else if (cmd.rd_len) begin
            ram_addr = WRAP_LUT[LEN_ADDR];
        end else if (cmd.rd_ctrl) begin
            ram_addr = WRAP_LUT[CTRL_ADDR];
        end else begin
            ram_addr = rd_ptr_reg;
        end
    end

    assign ram_en   = cmd.wr_store || cmd.rd_len || cmd.rd_ctrl || cmd.step;

    dtimtim_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (cmd.wr_store),
        .addr  (ram_addr),
        .wdata (store_data),
        .rdata (ram_rdata)
    );

    assign offset_calc = BITMAP_BASE + {ram_rdata[7:1], 1'b0};
    assign reach       = {1'b0, len_raw_reg} + {1'b0, offset_calc};
    assign len_calc    = (reach > {1'b0, limit_reg}) ? 8'd1 : len_raw_reg;

    always_comb begin
        case (pos_reg)
            9'd0:    cur_byte = TIM_EID;
            9'd1:    cur_byte = len_reg + TIM_FIXED_BODY;
            9'd2:    cur_byte = count_reg;
            9'd3:    cur_byte = period_reg;
            9'd4:    cur_byte = ctrl_reg;
            default: cur_byte = ram_rdata;
        endcase
    end

    assign new_word      = asm_word_reg | (64'(cur_byte) << {asm_cnt_reg[2:0], 3'b000});
    assign sts.last_byte = (pos_reg == total_reg - 9'd1);
    assign sts.word_done = (asm_cnt_reg == BPW_M1) || sts.last_byte;
    assign sts.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        count_next = count_reg;
        if (cmd.dtim_adv) begin
            count_next = (count_reg == 8'd0) ? period_reg - 8'd1 : count_reg - 8'd1;
        end else if (cmd.dtim_reload && (period_reg != 8'd0)) begin
            count_next = period_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= 8'd1;
            limit_reg     <= 8'd255;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            asm_cnt_reg   <= 4'd0;
            pos_reg       <= 9'd0;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DTIM_PERIOD:  period_reg <= cfg_data;
                    CFG_BITMAP_LIMIT: limit_reg  <= cfg_data;
                    default:          period_reg <= period_reg;
                endcase
            end
            if (cmd.load_setup) begin
                pos_reg     <= 9'd0;
                asm_cnt_reg <= 4'd0;
            end else if (cmd.step) begin
                pos_reg <= pos_next;
                if (sts.word_done) begin
                    asm_cnt_reg <= 4'd0;
                end else begin
                    asm_cnt_reg <= asm_cnt_reg + 4'd1;
                end
            end
            if (cmd.step && sts.word_done) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_ctrl) begin
            len_raw_reg <= ram_rdata;
        end
        if (cmd.load_setup) begin
            rd_ptr_reg <= WRAP_LUT[offset_calc];
        end else if (cmd.step && (pos_reg >= TIM_HEADER - 9'd1)) begin
            rd_ptr_reg <= rd_ptr_inc;
        end
        if (cmd.load_setup) begin
            ctrl_reg     <= ram_rdata;
            len_reg      <= len_calc;
            total_reg    <= TIM_HEADER + {1'b0, len_calc};
            asm_word_reg <= '0;
        end else if (cmd.step) begin
            asm_word_reg <= sts.word_done ? '0 : new_word;
        end
        if (cmd.step && sts.word_done) begin
            out_word_reg  <= new_word;
            out_cnt_reg   <= asm_cnt_reg + 4'd1;
            out_last_reg  <= sts.last_byte;
            out_len_reg   <= total_reg[7:0];
            out_mcast_reg <= ctrl_reg[0];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_element_word   = out_word_reg;
    assign m_byte_count     = out_cnt_reg;
    assign m_last_word      = out_last_reg;
    assign m_element_length = out_len_reg;
    assign m_mcast_buffered = out_mcast_reg;

    `ASSERT_CLK(a_out_cnt_range, out_valid_reg |-> (out_cnt_reg - 4'd1) < BPW_CNT, "bad byte count")
    `ASSERT_NEVER(a_asm_cnt_bound, asm_cnt_reg >= BPW_CNT, "assembly count overflow")
endmodule

/* rtl/dtim_count_and_tim_element_builder_unit.sv */
// Top level of the DTIM count keeper and TIM element builder
`timescale 1ns / 1ps
// Keeps a byte store for the traffic indication bitmap (byte 0 partial-bitmap
// length, byte 1 bitmap control, bitmap after that) and a DTIM counter. Store
// write, DTIM advance and DTIM reload items are handled in the idle state. A
// build item first fetches length and control from the single-port store, then
// steps one element byte per cycle (5 + bitmap length, so 5 to 260 bytes), since
// the store port delivers one byte a cycle, except that stepping stalls while a
// finished word waits on m_tready. The input is not taken during a build.
// Store contents are undefined after reset until written; there is no clearing
// pass. Configuration writes are taken every cycle and must only occur while idle.
module dtim_count_and_tim_element_builder_unit #(
    parameter int STORE_DEPTH    = 256,
    parameter int BYTES_PER_WORD = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] store_address, [15:8] store_data
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [63:0] element_word, [67:64] byte_count,
                                   // [75:68] element_length, [76] mcast_buffered
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import dtimtim_pkg::*;

    ctl_cmd_t    cmd;
    dp_sts_t     sts;
    req_type_t   req;
    logic [63:0] element_word;
    logic [3:0]  byte_count;
    logic [7:0]  element_length;
    logic        mcast_buffered;

    assign req       = req_type_t'(s_tuser);
    assign cfg_ready = 1'b1;

    dtimtim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_req   (req),
        .s_ready (s_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dtimtim_dp #(
        .STORE_DEPTH    (STORE_DEPTH),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .store_address    (s_tdata[7:0]),
        .store_data       (s_tdata[15:8]),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_element_word   (element_word),
        .m_byte_count     (byte_count),
        .m_last_word      (m_tlast),
        .m_element_length (element_length),
        .m_mcast_buffered (mcast_buffered)
    );

    assign m_tdata = {3'b000, mcast_buffered, element_length, byte_count, element_word};
endmodule
